// ----- src/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tbp_pkg: shared constants and types for the token bucket pacer
// Fixed-point format, field widths, register indexes and transaction kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbp_pkg;

    // fixed-point and field widths
    localparam int FRAC_BITS  = 24;
    localparam int TIME_BITS  = 48;
    localparam int RATE_W     = 32;
    localparam int BURST_W    = 24;
    localparam int PKT_W      = 16;
    localparam int WAIT_W     = 40;
    localparam int LVL_W      = BURST_W + FRAC_BITS;
    localparam int NEED_W     = PKT_W + FRAC_BITS;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RATE_W;

    // shared add/subtract unit: refill accumulator needs two bits over the
    // level, plus one bit for the borrow
    localparam int ALU_W      = LVL_W + 3;

    // iteration counts of the shared unit
    localparam int MUL_STEPS  = RATE_W;
    localparam int DIV_STEPS  = NEED_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE  = 1'b0,
        CFG_BURST = 1'b1
    } t_cfg_idx;

    // transaction kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ACQUIRE = 1'b1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [LVL_W-1:0]     t_level;
    typedef logic [ALU_W-1:0]     t_alu;

endpackage

// ----- src/token_bucket_pacer.sv -----
// ----------------------------------------------------------------------------
// token_bucket_pacer: token bucket rate limiter for packet pacing
// Refills a Q.24 token level from elapsed time, grants packets or reports
// the wait in nanoseconds, using one shared add/subtract unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// A start transaction fills the bucket to the burst cap and records the time;
// its result (granted 0, wait 0) is ready in the cycle after acceptance. An
// acquire transaction refills the bucket by elapsed time times rate, capped at
// the burst limit, then grants the packet or returns the wait in ns. All
// acquire arithmetic runs through one add/subtract unit under a sequencer:
// elapsed time and headroom setup, shift-and-add refill and a level update
// (both skipped when the level is already at the cap), a grant check, then
// for a denied packet with nonzero rate restoring division, and a final step
// to post the result. The input is not ready while an acquire is in progress
// or while a result waits in the output register and is not being taken.
module token_bucket_pacer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [tbp_pkg::TIME_BITS-1:0]    i_now_ns,
    input  logic [tbp_pkg::PKT_W-1:0]        i_packet_bytes,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_granted,
    output logic [tbp_pkg::WAIT_W-1:0]       o_wait_ns
);
    import tbp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ELAP = 8'b0000_0010,
        S_HEAD = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_UPD  = 8'b0001_0000,
        S_CHK  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [RATE_W-1:0]    r_rate;
    logic [BURST_W-1:0]   r_burst;
    t_level               r_level;
    t_time                r_last;
    t_time                r_now;
    logic [NEED_W-1:0]    r_need;
    t_time                r_elap;
    t_level               r_head;
    t_level               r_acc;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_cnt;
    logic [RATE_W-1:0]    r_rem;
    logic [NEED_W-1:0]    r_quo;
    logic                 r_gr;
    logic                 r_out_valid;
    logic                 r_out_granted;
    logic [WAIT_W-1:0]    r_out_wait;

    t_level               cap;
    t_level               need_ext;
    logic                 lvl_ge_cap;
    logic                 lvl_ge_need;
    logic                 in_fire;
    logic                 out_free;
    logic                 out_post;
    logic                 borrow;
    t_alu                 alu_a, alu_b, alu_y;
    logic                 alu_sub;

    // bucket cap and packet need in Q.24
    assign cap         = {r_burst, {FRAC_BITS{1'b0}}};
    assign need_ext    = LVL_W'(r_need);
    assign lvl_ge_cap  = (r_level >= cap);
    assign lvl_ge_need = (r_level >= need_ext);

    // handshakes
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_post    = (in_fire && (i_kind == KIND_START)) ||
                         ((r_state == S_DONE) && out_free);
    assign o_out_valid = r_out_valid;
    assign o_granted   = r_out_granted;
    assign o_wait_ns   = r_out_wait;

    // shared add/subtract unit operand select
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_ELAP: begin
                alu_a   = ALU_W'(r_now);
                alu_b   = ALU_W'(r_last);
                alu_sub = 1'b1;
            end
            S_HEAD: begin
                alu_a   = ALU_W'(cap);
                alu_b   = ALU_W'(r_level);
                alu_sub = 1'b1;
            end
            S_MUL: begin
                alu_a   = ALU_W'({r_acc, 1'b0});
                alu_b   = r_rate[r_cnt[$clog2(MUL_STEPS)-1:0]] ? ALU_W'(r_elap) : '0;
                alu_sub = 1'b0;
            end
            S_UPD: begin
                alu_a   = ALU_W'(r_level);
                alu_b   = ALU_W'(r_acc);
                alu_sub = 1'b0;
            end
            S_CHK: begin
                alu_sub = 1'b1;
                if (lvl_ge_need) begin
                    alu_a = ALU_W'(r_level);
                    alu_b = ALU_W'(need_ext);
                end else begin
                    alu_a = ALU_W'(need_ext);
                    alu_b = ALU_W'(r_level);
                end
            end
            S_DIV: begin
                alu_a   = ALU_W'({r_rem, r_quo[NEED_W-1]});
                alu_b   = ALU_W'(r_rate);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    assign borrow = alu_y[ALU_W-1];

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && (i_kind == KIND_ACQUIRE)) n_state = S_ELAP;
            end
            S_ELAP: n_state = S_HEAD;
            S_HEAD: n_state = lvl_ge_cap ? S_CHK : S_MUL;
            S_MUL: begin
                if (r_cnt == '0) n_state = S_UPD;
            end
            S_UPD: n_state = S_CHK;
            S_CHK: begin
                if (lvl_ge_need || (r_rate == '0)) n_state = S_DONE;
                else n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state, bucket state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_W'(209715);
            r_burst     <= BURST_W'(1250000);
            r_level     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RATE:  r_rate  <= i_cfg_data;
                    CFG_BURST: r_burst <= i_cfg_data[BURST_W-1:0];
                    default:   r_rate  <= r_rate;
                endcase
            end

            // output register loads a result or drains on transaction
            if (out_post) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_kind == KIND_START)) begin
                        r_level <= cap;
                        r_last  <= i_now_ns;
                    end
                end
                S_ELAP: r_last <= r_now;
                S_HEAD: begin
                    if (lvl_ge_cap) r_level <= cap;
                end
                S_UPD: r_level <= r_ovf ? cap : alu_y[LVL_W-1:0];
                S_CHK: begin
                    if (lvl_ge_need) r_level <= alu_y[LVL_W-1:0];
                end
                default: r_level <= r_level;
            endcase
        end
    end

    // datapath registers of the shared unit
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_now         <= i_now_ns;
                    r_need        <= {i_packet_bytes, {FRAC_BITS{1'b0}}};
                    r_out_granted <= 1'b0;
                    r_out_wait    <= '0;
                end
            end
            // elapsed time modulo the time width
            S_ELAP: r_elap <= alu_y[TIME_BITS-1:0];
            // headroom below the cap, start refill product
            S_HEAD: begin
                r_head <= alu_y[LVL_W-1:0];
                r_acc  <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= CNT_W'(MUL_STEPS - 1);
            end
            // msb-first shift-and-add of elapsed times rate, sticky overflow
            S_MUL: begin
                if (!r_ovf) begin
                    if (alu_y > ALU_W'(r_head)) r_ovf <= 1'b1;
                    else r_acc <= alu_y[LVL_W-1:0];
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
            // grant, zero-rate saturation, or start division of the deficit
            S_CHK: begin
                if (lvl_ge_need) begin
                    r_gr  <= 1'b1;
                    r_quo <= '0;
                end else if (r_rate == '0) begin
                    r_gr  <= 1'b0;
                    r_quo <= '1;
                end else begin
                    r_gr  <= 1'b0;
                    r_quo <= alu_y[NEED_W-1:0];
                    r_rem <= '0;
                    r_cnt <= CNT_W'(DIV_STEPS - 1);
                end
            end
            // restoring division, one quotient bit per cycle
            S_DIV: begin
                if (borrow) r_rem <= {r_rem[RATE_W-2:0], r_quo[NEED_W-1]};
                else r_rem <= alu_y[RATE_W-1:0];
                r_quo <= {r_quo[NEED_W-2:0], !borrow};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            // post result
            S_DONE: begin
                if (out_free) begin
                    r_out_granted <= r_gr;
                    r_out_wait    <= WAIT_W'(r_quo);
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    // checks
    a_grant_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted |-> (o_wait_ns == '0))
        else $error("granted result carries a nonzero wait");

    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_kind == KIND_START)
            |=> o_out_valid && !o_granted && (o_wait_ns == '0))
        else $error("start transaction did not post its result");

    a_acquire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_kind == KIND_ACQUIRE) |=> !o_in_ready && !$past(o_out_valid && !i_out_ready))
        else $error("input ready while an acquire is in progress");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rate != '0) && (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("division running with zero rate or bad count");

endmodule

// ----- tb/tbp_checker.sv -----
// ----------------------------------------------------------------------------
// tbp_checker: pacing predictor and result checker
// Watches the config port and both channels of the token bucket pacer.
// Predicts the grant or wait for every accepted transaction and compares
// each returned result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic                             i_kind,
    input  logic [tbp_pkg::TIME_BITS-1:0]    i_now_ns,
    input  logic [tbp_pkg::PKT_W-1:0]        i_packet_bytes,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_granted,
    input  logic [tbp_pkg::WAIT_W-1:0]       i_wait_ns,
    output int                               o_fail_count,
    output int                               o_pending
);

    import tbp_pkg::*;

    localparam logic [63:0] WAIT_CEIL    = (64'd1 << WAIT_W) - 64'd1;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic              granted;
        logic [WAIT_W-1:0] wait_ns;
    } t_pacing_verdict;

    // shadow copy of the configuration and the bucket
    logic [63:0]          rate_setting;
    logic [BURST_W-1:0]   burst_setting;
    logic [63:0]          bucket_level;
    logic [TIME_BITS-1:0] last_stamp;

    t_pacing_verdict pending_verdicts[$];
    t_pacing_verdict oldest;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // refill, then grant or work out the wait for one transaction
    function automatic t_pacing_verdict predict_pacing(input logic kind,
                                                       input logic [TIME_BITS-1:0] now,
                                                       input logic [PKT_W-1:0] pkt);
        logic [63:0]     cap;
        logic [63:0]     need;
        logic [63:0]     elapsed;
        logic [63:0]     headroom;
        logic [63:0]     wait_full;
        t_pacing_verdict v;
        cap       = {40'd0, burst_setting} << FRAC_BITS;
        need      = {48'd0, pkt} << FRAC_BITS;
        v.granted = 1'b0;
        v.wait_ns = '0;
        if (kind == KIND_START) begin
            bucket_level = cap;
            last_stamp   = now;
        end else begin
            elapsed = {16'd0, now - last_stamp};
            if (bucket_level >= cap) begin
                bucket_level = cap;
            end else begin
                headroom = cap - bucket_level;
                // saturate before the product could pass the cap
                if (rate_setting != 0 && elapsed > headroom / rate_setting)
                    bucket_level = cap;
                else
                    bucket_level = bucket_level + elapsed * rate_setting;
            end
            last_stamp = now;
            if (bucket_level >= need) begin
                bucket_level = bucket_level - need;
                v.granted    = 1'b1;
            end else begin
                if (rate_setting == 0)
                    wait_full = WAIT_CEIL;
                else
                    wait_full = (need - bucket_level) / rate_setting;
                if (wait_full > WAIT_CEIL)
                    wait_full = WAIT_CEIL;
                v.wait_ns = wait_full[WAIT_W-1:0];
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        if (o_fail_count < REPORT_LIMIT)
            $display("mismatch in %s at %0t: expected %0d, got %0d", field, $time, want, got);
        o_fail_count++;
    endtask

    // track config writes, check results, queue predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_setting  = 64'd209715;
            burst_setting = 24'd1250000;
            bucket_level  = 64'd0;
            last_stamp    = '0;
            pending_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATE:  rate_setting  = {32'd0, i_cfg_data};
                    CFG_BURST: burst_setting = i_cfg_data[BURST_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    if (o_fail_count < REPORT_LIMIT)
                        $display("unexpected result at %0t: granted %0d wait %0d",
                                 $time, i_granted, i_wait_ns);
                    o_fail_count++;
                end else begin
                    oldest = pending_verdicts.pop_front();
                    if (i_granted !== oldest.granted)
                        report_mismatch("granted", {63'd0, oldest.granted}, {63'd0, i_granted});
                    if (i_wait_ns !== oldest.wait_ns)
                        report_mismatch("wait_ns", {24'd0, oldest.wait_ns}, {24'd0, i_wait_ns});
                end
            end
            if (i_in_valid && i_in_ready)
                pending_verdicts.push_back(predict_pacing(i_kind, i_now_ns, i_packet_bytes));
        end
        o_pending = pending_verdicts.size();
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the token bucket pacer
// Runs directed corner cases, then randomized pacing phases under several
// rate and burst settings, with random idling on both channels and one long
// receiver stall. Checking is done by the tbp_checker instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import tbp_pkg::*;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 95;
    localparam int HOLD_AT_ITEM = 500;
    localparam int HOLD_CYCLES  = 400;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx        = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic                  kind           = KIND_START;
    logic [TIME_BITS-1:0]  now_ns         = '0;
    logic [PKT_W-1:0]      packet_bytes   = '0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic                  granted;
    logic [WAIT_W-1:0]     wait_ns;
    int                    fail_count;
    int                    pending;

    int                    items_sent     = 0;
    int                    cycle_count    = 0;
    logic [31:0]           cur_rate       = 32'd209715;
    logic [TIME_BITS-1:0]  clock_ns       = '0;

    token_bucket_pacer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_kind         (kind),
        .i_now_ns       (now_ns),
        .i_packet_bytes (packet_bytes),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_granted      (granted),
        .o_wait_ns      (wait_ns)
    );

    tbp_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_kind         (kind),
        .i_now_ns       (now_ns),
        .i_packet_bytes (packet_bytes),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_granted      (granted),
        .i_wait_ns      (wait_ns),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // random gap length: mostly short, a few long, none in quiet stretches
    function automatic int pick_gap(input int stretch);
        int r;
        r = $urandom_range(0, 99);
        if ((stretch % 200) < 30) return 0;
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // receiver side: random back-pressure plus one long hold-off
    initial begin
        int gap_left;
        int hold_count;
        bit hold_done;
        gap_left  = 0;
        hold_done = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
                hold_done = 1;
                out_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge i_clk);
            end else if (gap_left > 0) begin
                out_ready <= 1'b0;
                gap_left--;
                @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                gap_left = pick_gap(cycle_count / 3);
                @(posedge i_clk);
            end
        end
    end

    // offer one transaction and wait until it is accepted
    task automatic send_item(input logic k, input logic [TIME_BITS-1:0] t,
                             input logic [PKT_W-1:0] len);
        int gap;
        gap = pick_gap(items_sent);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        now_ns       <= t;
        packet_bytes <= len;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // drain all outstanding results, then let the sequencer go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] rate, input logic [BURST_W-1:0] burst);
        settle();
        write_reg(CFG_RATE, rate);
        write_reg(CFG_BURST, {8'd0, burst});
        cur_rate = rate;
    endtask

    // mostly an acquire, sometimes a start, with a time step scaled to the refill time of the packet
    task automatic send_random_acquire();
        int          r;
        logic [15:0] len;
        logic [63:0] fill_time;
        logic [63:0] step;
        logic [63:0] jump;
        r = $urandom_range(0, 99);
        if (r < 10)      len = 16'd0;
        else if (r < 22) len = 16'($urandom());
        else if (r < 27) len = 16'hFFFF;
        else             len = 16'($urandom_range(40, 1500));
        r = $urandom_range(0, 99);
        if (cur_rate == 0 || r < 15) begin
            step = 64'($urandom_range(0, 50));
        end else begin
            fill_time = ({48'd0, len} << FRAC_BITS) / {32'd0, cur_rate};
            if (fill_time > 64'hFF_FFFF_FFFF) fill_time = 64'hFF_FFFF_FFFF;
            step = fill_time * 64'($urandom_range(0, 200)) / 64'd100;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            // arbitrary jump, often backwards
            jump     = {$urandom(), $urandom()};
            clock_ns = jump[TIME_BITS-1:0];
        end else begin
            clock_ns = clock_ns + step[TIME_BITS-1:0];
        end
        if (r >= 3 && r < 7)
            send_item(KIND_START, clock_ns, len);
        else
            send_item(KIND_ACQUIRE, clock_ns, len);
    endtask

    // main stimulus
    initial begin
        int          p;
        int          n;
        logic [31:0] rate;
        logic [23:0] burst;
        logic [63:0] seed_time;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // acquire before any start, zero-length packet, then a full bucket
        send_item(KIND_ACQUIRE, 48'd1000, 16'd100);
        send_item(KIND_ACQUIRE, 48'd1000, 16'd0);
        send_item(KIND_START, 48'd2000, 16'hFFFF);
        send_item(KIND_ACQUIRE, 48'd2000, 16'hFFFF);
        send_item(KIND_ACQUIRE, 48'd2005, 16'd0);

        // burst lowered below the level, then time wrap
        apply_setting(32'h0100_0000, 24'd100);
        send_item(KIND_ACQUIRE, 48'd2010, 16'd50);
        send_item(KIND_ACQUIRE, 48'd2010, 16'd60);
        send_item(KIND_ACQUIRE, 48'd2030, 16'd60);
        send_item(KIND_ACQUIRE, 48'hFFFF_FFFF_FFFB, 16'hFFFF);
        send_item(KIND_ACQUIRE, 48'd3, 16'd100);

        // zero rate, largest and empty bucket
        apply_setting(32'd0, 24'hFF_FFFF);
        send_item(KIND_START, 48'hFFFF_FFFF_FFFF, 16'd0);
        send_item(KIND_ACQUIRE, 48'd0, 16'hFFFF);
        apply_setting(32'd0, 24'd0);
        send_item(KIND_ACQUIRE, 48'd10, 16'd1);
        send_item(KIND_ACQUIRE, 48'd11, 16'd0);

        // largest rate: refill product would overflow the cap
        apply_setting(32'hFFFF_FFFF, 24'd1);
        send_item(KIND_START, 48'd0, 16'd0);
        send_item(KIND_ACQUIRE, 48'd0, 16'd1);
        send_item(KIND_ACQUIRE, 48'd0, 16'd1);
        send_item(KIND_ACQUIRE, 48'd1, 16'd1);

        // smallest nonzero rate, longest waits
        apply_setting(32'd1, 24'hFF_FFFF);
        send_item(KIND_ACQUIRE, 48'd1, 16'hFFFF);
        send_item(KIND_ACQUIRE, 48'h8000_0000_0001, 16'd1);

        // random pacing phases
        for (p = 0; p < PHASES; p++) begin
            case (p % 6)
                0: rate = 32'd209715;
                1: rate = $urandom_range(32'h0001_0000, 32'h0400_0000);
                2: rate = (p < 6) ? 32'd0 : $urandom_range(1, 255);
                3: rate = 32'hFFFF_FFFF;
                4: rate = $urandom();
                default: rate = 32'd1;
            endcase
            case (p % 5)
                0: burst = 24'd1250000;
                1: burst = 24'($urandom_range(1, 100000));
                2: burst = 24'hFF_FFFF;
                3: burst = 24'($urandom());
                default: burst = 24'($urandom_range(0, 3000));
            endcase
            apply_setting(rate, burst);
            if (p % 2 == 1) begin
                seed_time = {$urandom(), $urandom()};
                clock_ns  = seed_time[TIME_BITS-1:0];
            end
            send_item(KIND_START, clock_ns, 16'($urandom()));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_acquire();
        end

        // drain and give the verdict
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
